// ===== design/bdq_pkg.sv =====
// Shared types, constants and ring arithmetic for the byte deque.
// No dependencies; every other design file imports this package.
package bdq_pkg;

	// Ring geometry
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OP_W     = 3;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 7;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PURGE      = 3'd4,
		OP_SIZE       = 3'd5
	} op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic scan;
		logic finish;
		logic emit;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_purge;
		logic has_result;
		logic scan_end;
		logic out_free;
	} dp_stat_t;

	// Ring slot that lies off entries past front; off stays below CAPACITY
	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] front,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(front) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// ===== design/bdq_ctrl.sv =====
// Sequencing state machine of the byte deque.
// Depends on bdq_pkg; drives commands to bdq_dpath and reads its status.
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bdq_pkg::dp_stat_t stat,
	output bdq_pkg::ctl_cmd_t cmd
);
	import bdq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Decode commands from the current state
	always_comb begin
		cmd        = '0;
		in_stall   = 1'b1;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					priority if (stat.is_purge) begin
						state_d = ST_SCAN;
					end else if (stat.has_result) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan   = !stat.scan_end;
				cmd.finish = stat.scan_end;
				if (stat.scan_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = stat.out_free;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/bdq_dpath.sv =====
// Ring store, pointers, purge walk and output register of the byte deque.
// Depends on bdq_pkg; acts on commands from bdq_ctrl.
module bdq_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bdq_pkg::OP_W-1:0]      op,
	input  logic [bdq_pkg::BYTE_W-1:0]    byte_value,
	input  bdq_pkg::ctl_cmd_t             cmd,
	output bdq_pkg::dp_stat_t             stat,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdq_pkg::COUNT_W-1:0]   count,
	output logic [bdq_pkg::BYTE_W-1:0]    byte_out,
	output logic                          rejected
);
	import bdq_pkg::*;

	logic [BYTE_W-1:0] mem [CAPACITY];
	logic [BYTE_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  front_q;
	logic [CNT_W-1:0]  occ_q;
	logic              rd_vld_s1;
	logic              out_valid_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  kept_q;
	logic [BYTE_W-1:0] val_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [BYTE_W-1:0] res_byte_q;
	logic              res_mem_q;
	logic              res_rej_q;
	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0] byte_out_q;
	logic              rejected_q;

	op_t               op_in;
	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  front_dec;
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              scan_more;
	logic              keep_hit;

	assign op_in     = op_t'(op);
	assign full      = (occ_q == CNT_W'(CAPACITY));
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);
	assign scan_more = (scan_q != occ_q);
	assign keep_hit  = cmd.scan && rd_vld_s1 && (rd_data_q != val_q);

	// Status towards the controller
	always_comb begin
		stat.is_purge   = (op_in == OP_PURGE);
		stat.scan_end   = !scan_more && !rd_vld_s1;
		stat.out_free   = !out_valid_q || !out_stall;
		unique case (op_in)
			OP_PUSH_FRONT, OP_PUSH_BACK:           stat.has_result = full;
			OP_POP_FRONT, OP_POP_BACK, OP_PURGE,
			OP_SIZE:                               stat.has_result = 1'b1;
			default:                               stat.has_result = 1'b0;
		endcase
	end

	// Select memory port addresses
	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		wr_addr = front_dec;
		rd_addr = front_q;
		wr_data = byte_value;
		if (cmd.accept) begin
			unique case (op_in)
				OP_PUSH_FRONT: begin
					mem_we  = !full;
					wr_addr = front_dec;
				end
				OP_PUSH_BACK: begin
					mem_we  = !full;
					wr_addr = ring_pos(front_q, occ_q);
				end
				OP_POP_FRONT: begin
					mem_re  = !empty;
					rd_addr = front_q;
				end
				OP_POP_BACK: begin
					mem_re  = !empty;
					rd_addr = ring_pos(front_q, occ_q - CNT_W'(1));
				end
				default: begin
					mem_re = 1'b0;
				end
			endcase
		end else if (cmd.scan) begin
			mem_re  = scan_more;
			rd_addr = ring_pos(front_q, scan_q);
			mem_we  = keep_hit;
			wr_addr = ring_pos(front_q, kept_q);
			wr_data = rd_data_q;
		end
	end

	// Ring store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Pointers, walk valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			occ_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				unique case (op_in)
					OP_PUSH_FRONT: begin
						if (!full) begin
							front_q <= front_dec;
							occ_q   <= occ_q + CNT_W'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (!full) begin
							occ_q <= occ_q + CNT_W'(1);
						end
					end
					OP_POP_FRONT: begin
						if (!empty) begin
							front_q <= ring_pos(front_q, CNT_W'(1));
							occ_q   <= occ_q - CNT_W'(1);
						end
					end
					OP_POP_BACK: begin
						if (!empty) begin
							occ_q <= occ_q - CNT_W'(1);
						end
					end
					OP_PURGE: begin
						rd_vld_s1 <= 1'b0;
					end
					default: begin
						rd_vld_s1 <= 1'b0;
					end
				endcase
			end
			if (cmd.scan) begin
				rd_vld_s1 <= scan_more;
			end
			if (cmd.finish) begin
				occ_q <= kept_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk counters, staged result and output beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_cnt_q  <= '0;
			res_byte_q <= '0;
			res_mem_q  <= 1'b0;
			res_rej_q  <= 1'b0;
			scan_q     <= '0;
			kept_q     <= '0;
			val_q      <= byte_value;
			unique case (op_in)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					res_rej_q <= full;
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					res_cnt_q <= empty ? '0 : CNT_W'(1);
					res_mem_q <= !empty;
				end
				OP_SIZE: begin
					res_cnt_q <= occ_q;
				end
				default: begin
					res_rej_q <= 1'b0;
				end
			endcase
		end
		if (cmd.scan) begin
			if (scan_more) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (keep_hit) begin
				kept_q <= kept_q + CNT_W'(1);
			end
		end
		if (cmd.finish) begin
			res_cnt_q  <= occ_q - kept_q;
			res_byte_q <= (occ_q != kept_q) ? val_q : '0;
		end
		if (cmd.emit) begin
			count_q    <= COUNT_W'(res_cnt_q);
			byte_out_q <= res_mem_q ? rd_data_q : res_byte_q;
			rejected_q <= res_rej_q;
		end
	end

	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign byte_out  = byte_out_q;
	assign rejected  = rejected_q;

endmodule

// ===== design/byte_deque_with_value_purge.sv =====
// Byte deque in a ring of CAPACITY entries, with push/pop at both ends and value purge.
// A successful push gives no result beat; the controller stays idle for the next item.
// Pop, size and a rejected push go to the emit state, which loads the result beat into
// the output register once it is free (registered memory read). A purge walks the held
// entries one per cycle, then finishes, emits its result and returns to idle; output stalls delay both.
// One item is in work at a time. Reset (arst_n low) empties the deque at once.
module byte_deque_with_value_purge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdq_pkg::OP_W-1:0]      op,
	input  logic [bdq_pkg::BYTE_W-1:0]    byte_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdq_pkg::COUNT_W-1:0]   count,
	output logic [bdq_pkg::BYTE_W-1:0]    byte_out,
	output logic                          rejected
);
	import bdq_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bdq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.byte_value (byte_value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.count      (count),
		.byte_out   (byte_out),
		.rejected   (rejected)
	);

	// Load the output register only when it is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result loaded into a busy output register");

	// A taken purge holds off the next beat while it walks
	a_purge_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && op == OP_PURGE) |=> in_stall)
		else $error("input taken during a purge walk");

	// A new result beat comes only from an emit command
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("output valid raised without a result");

endmodule
